@@ rtl/emlp_pkg.sv @@
// Shared constants, codes and types for the energy monitor line parser.
package emlp_pkg;

  localparam int NUM_SENSORS_DEF   = 12;
  localparam int LINE_CAPACITY_DEF = 511;

  // operation codes carried in s_tuser
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // result kinds carried in m_tuser
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;
  localparam int SNUM_W     = 4;
  localparam int WATTS_W    = 17;
  localparam int WINDOW_W   = 16;
  localparam int TIME_W     = 32;

  // output tdata bit positions
  localparam int OUT_POWER_LSB = SNUM_W;
  localparam int OUT_FRESH_BIT = SNUM_W + WATTS_W;

  localparam logic [WATTS_W-1:0]  WATTS_MAX    = 17'd99999;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd90;

  localparam int TAG_SENSOR_LEN = 8;
  localparam int TAG_WATTS_LEN  = 7;
  localparam logic [8*TAG_SENSOR_LEN-1:0] TAG_SENSOR = "<sensor>";
  localparam logic [8*TAG_WATTS_LEN-1:0]  TAG_WATTS  = "<watts>";

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // per-character control handed to each field reader
  typedef struct packed {
    logic       feed;
    logic       clear;
    logic [7:0] ch;
  } fld_ctl_t;

endpackage

@@ rtl/energy_monitor_line_parser_unit.sv @@
// Top level of the energy monitor line parser: input stage, line state and result register.
//
// Usage notes
// - s_* channel: one beat per operation. s_tuser = operation (byte, tick, read).
//   s_tdata[7:0] = received character, s_tdata[11:8] = sensor to read.
// - m_* channel: one beat per result. m_tuser = kind (0 stored at line end,
//   1 read reply); m_tdata carries sensor number, power and fresh flag.
// - cfg_* channel: writes the freshness window in seconds; always ready.
//   Write it only while no beats are in flight.
// - Path: a beat taken passes the input register, then the result register.
//   Throughput is one beat per cycle while m_tready stays high; the
//   per-character tag match and one decimal multiply-add set that figure.
// - Bytes and ticks that produce nothing still pass the input
//   register and leave no beat on m_*.
// - When m_tready is held low the result register holds its beat, the input
//   register fills, then s_tready falls; nothing is dropped.
// - Reset (rst, synchronous) empties both registers, the line being parsed,
//   the seconds count and all stored readings; the window returns to 90 s.
module energy_monitor_line_parser_unit import emlp_pkg::*; #(
  parameter int NUM_SENSORS   = NUM_SENSORS_DEF,
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // rx_byte[7:0], read_index[11:8], zero[15:12]
  input  logic [1:0]            s_tuser,   // operation[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // sensor_number[3:0], power_watts[20:4],
                                           // fresh[21], zero[23:22]
  output logic                  m_tuser,   // kind[0]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [WINDOW_W-1:0]   cfg_data   // fresh_window[15:0]
);

  localparam int SIDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int IDXE_W = (SIDX_W > SNUM_W) ? SIDX_W : SNUM_W;
  localparam int SVAL_W = $clog2(NUM_SENSORS + 1);
  localparam int CNT_W  = $clog2(LINE_CAPACITY + 1);

  // input register
  logic              in_valid;
  logic [1:0]        in_op;
  logic [7:0]        in_ch;
  logic [SNUM_W-1:0] in_idx;
  logic              adv, take, proc;

  // line state
  logic [7:0]       held_char;
  logic             held_valid;
  logic [CNT_W-1:0] line_count, count_inc;
  logic             nul_end;
  logic [TIME_W-1:0]   seconds_now;
  logic [WINDOW_W-1:0] fresh_window;

  // per-sensor store
  logic [WATTS_W-1:0] stored_power [NUM_SENSORS];
  logic [TIME_W-1:0]  stored_time  [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] stored_valid;

  // field readers
  fld_ctl_t          ctl;
  logic              s_found, w_found, s_neg, w_neg;
  logic [SVAL_W-1:0] s_val;
  logic [WATTS_W-1:0] w_val;

  logic is_byte, is_nl, is_read, overflow, line_clear, ch_feed, store_en;
  logic [SIDX_W-1:0]  wr_sel, rd_sel;
  logic [IDXE_W-1:0]  idx_ext;
  logic [SVAL_W+SNUM_W-1:0] s_val_ext;
  logic [WATTS_W-1:0] pw_line, rd_power;
  logic [TIME_W-1:0]  age;
  logic               rd_in_range, rd_hit, rd_fresh;

  // result register payload
  logic [OUT_DATA_W-1:0] m_tdata_next;
  logic                  m_tuser_next;

  // ---- handshakes ----
  assign adv       = !m_tvalid || m_tready;   // result register can take a beat
  assign s_tready  = !in_valid || adv;
  assign take      = s_tvalid && s_tready;
  assign proc      = in_valid && adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_op  <= s_tuser;
      in_ch  <= s_tdata[7:0];
      in_idx <= s_tdata[11:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_window <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fresh_window <= cfg_data;
    end
  end

  // ---- line handling ----
  assign is_byte    = proc && (in_op == OP_BYTE);
  assign is_read    = proc && (in_op == OP_READ);
  assign is_nl      = (in_ch == CH_NL);
  assign count_inc  = line_count + CNT_W'(1);
  assign overflow   = !is_nl && (count_inc >= CNT_W'(LINE_CAPACITY));
  assign line_clear = is_byte && (is_nl || overflow);
  // each character is held back one beat; a newline drops it
  assign ch_feed    = is_byte && !is_nl && held_valid && !nul_end && (held_char != CH_NUL);

  assign ctl = '{feed: ch_feed, clear: line_clear, ch: held_char};

  always_ff @(posedge clk) begin
    if (rst || line_clear) begin
      held_valid <= 1'b0;
      line_count <= '0;
      nul_end    <= 1'b0;
    end else if (is_byte) begin
      held_valid <= 1'b1;
      line_count <= count_inc;
      if (held_valid && (held_char == CH_NUL)) nul_end <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (is_byte && !line_clear) held_char <= in_ch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_now <= '0;
    end else if (proc && (in_op == OP_TICK)) begin
      seconds_now <= seconds_now + TIME_W'(1);
    end
  end

  emlp_field #(
    .TAG_LEN (TAG_SENSOR_LEN),
    .TAG     (TAG_SENSOR),
    .VAL_W   (SVAL_W),
    .VAL_CAP (SVAL_W'(NUM_SENSORS))
  ) u_sensor (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .found    (s_found),
    .value    (s_val),
    .negative (s_neg)
  );

  emlp_field #(
    .TAG_LEN (TAG_WATTS_LEN),
    .TAG     (TAG_WATTS),
    .VAL_W   (WATTS_W),
    .VAL_CAP (WATTS_MAX)
  ) u_watts (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .found    (w_found),
    .value    (w_val),
    .negative (w_neg)
  );

  // ---- store at end of line ----
  // minus zero is a valid sensor; any other negative number is rejected
  assign store_en = is_byte && is_nl && s_found && w_found &&
                    ((s_val == '0) || !s_neg) && (int'(s_val) < NUM_SENSORS);
  assign pw_line  = w_neg ? '0 : w_val;
  assign wr_sel   = s_val[SIDX_W-1:0];
  assign s_val_ext = {{SNUM_W{1'b0}}, s_val};

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_valid <= '0;
    end else if (store_en) begin
      stored_valid[wr_sel] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      stored_power[wr_sel] <= pw_line;
      stored_time[wr_sel]  <= seconds_now;
    end
  end

  // ---- read reply ----
  assign idx_ext     = IDXE_W'(in_idx);
  assign rd_sel      = idx_ext[SIDX_W-1:0];
  assign rd_in_range = int'(in_idx) < NUM_SENSORS;
  assign rd_hit      = rd_in_range && stored_valid[rd_sel];
  assign age         = seconds_now - stored_time[rd_sel];   // wraps modulo 2^32
  assign rd_fresh    = rd_hit && (age < TIME_W'(fresh_window));
  assign rd_power    = rd_hit ? stored_power[rd_sel] : '0;

  // ---- result register ----
  always_comb begin
    if (store_en) begin
      m_tuser_next = KIND_STORE;
      m_tdata_next = {2'b00, 1'b1, pw_line, s_val_ext[SNUM_W-1:0]};
    end else begin
      m_tuser_next = KIND_READ;
      m_tdata_next = {2'b00, rd_fresh, rd_power, in_idx};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= store_en || is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && (store_en || is_read)) begin
      m_tdata <= m_tdata_next;
      m_tuser <= m_tuser_next;
    end
  end

endmodule

@@ rtl/emlp_field.sv @@
// Tag matcher and decimal number reader for one field of a line.
module emlp_field import emlp_pkg::*; #(
  parameter int                   TAG_LEN = TAG_SENSOR_LEN,
  parameter logic [8*TAG_LEN-1:0] TAG     = TAG_SENSOR,
  parameter int                   VAL_W   = 5,
  parameter logic [VAL_W-1:0]     VAL_CAP = VAL_W'(NUM_SENSORS_DEF)
) (
  input  logic             clk,
  input  logic             rst,
  input  fld_ctl_t         ctl,
  output logic             found,
  output logic [VAL_W-1:0] value,
  output logic             negative
);

  localparam int PROG_W = $clog2(TAG_LEN + 1);
  localparam int PROD_W = VAL_W + 4;

  localparam logic [1:0] PH_TAG   = 2'd0;
  localparam logic [1:0] PH_LEAD  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  logic [PROG_W-1:0] prog, prog_next;
  logic [1:0]        phase, phase_next;
  logic [VAL_W-1:0]  value_next;
  logic              negative_next;

  logic [7:0]        expected;
  logic              hit, is_digit, is_space;
  logic [3:0]        digit;
  logic [VAL_W-1:0]  base, acc;
  logic [PROD_W-1:0] prod;

  always_comb begin
    expected = TAG[8*TAG_LEN-1 -: 8];
    for (int i = 0; i < TAG_LEN; i++) begin
      if (prog == PROG_W'(i)) expected = TAG[8*(TAG_LEN-1-i) +: 8];
    end
  end

  assign hit      = (prog < PROG_W'(TAG_LEN)) && (ctl.ch == expected);
  assign is_digit = (ctl.ch >= CH_ZERO) && (ctl.ch <= CH_NINE);
  assign is_space = (ctl.ch == CH_SP) || (ctl.ch == CH_TAB) || (ctl.ch == CH_VT) ||
                    (ctl.ch == CH_FF) || (ctl.ch == CH_CR);
  assign digit    = 4'(ctl.ch - CH_ZERO);

  // first digit starts from zero, later ones shift the value a decade
  assign base = (phase == PH_DIGIT) ? value : '0;
  assign prod = PROD_W'(base) * PROD_W'(10) + PROD_W'(digit);
  assign acc  = (prod > PROD_W'(VAL_CAP)) ? VAL_CAP : prod[VAL_W-1:0];

  always_comb begin
    prog_next     = prog;
    phase_next    = phase;
    value_next    = value;
    negative_next = negative;
    unique case (phase)
      PH_TAG: begin
        if (hit) begin
          prog_next = prog + PROG_W'(1);
        end else begin
          prog_next = (ctl.ch == TAG[8*TAG_LEN-1 -: 8]) ? PROG_W'(1) : '0;
        end
        if (prog_next == PROG_W'(TAG_LEN)) phase_next = PH_LEAD;
      end
      PH_LEAD: begin
        if (ctl.ch == CH_PLUS) begin
          phase_next = PH_DIGIT;
        end else if (ctl.ch == CH_MINUS) begin
          negative_next = 1'b1;
          phase_next    = PH_DIGIT;
        end else if (is_digit) begin
          value_next = acc;
          phase_next = PH_DIGIT;
        end else if (!is_space) begin
          phase_next = PH_DONE;
        end
      end
      PH_DIGIT: begin
        if (is_digit) begin
          value_next = acc;
        end else begin
          phase_next = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      prog     <= '0;
      phase    <= PH_TAG;
      value    <= '0;
      negative <= 1'b0;
    end else if (ctl.feed) begin
      prog     <= prog_next;
      phase    <= phase_next;
      value    <= value_next;
      negative <= negative_next;
    end
  end

  assign found = (phase != PH_TAG);

endmodule

@@ rtl/emlp_checker.sv @@
// Port-level checks for the energy monitor line parser, bound to the top level.
module emlp_checker import emlp_pkg::*; #(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat present after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result beat changed");

  a_store_fresh: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_STORE) |->
      m_tdata[OUT_FRESH_BIT] && (int'(m_tdata[SNUM_W-1:0]) < NUM_SENSORS))
    else $error("stored reading not fresh or sensor out of range");

  a_power_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_FRESH_BIT-1:OUT_POWER_LSB] <= WATTS_MAX))
    else $error("power above limit");

  a_no_idle_block: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

endmodule

bind energy_monitor_line_parser_unit emlp_checker #(.NUM_SENSORS(NUM_SENSORS)) u_emlp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
